// File: hdl/phds_pkg.sv
// ----------------------------------------------------------------------------
// phds_pkg: shared types and constants
// Word widths, table geometry, register indexes and sequencer types of the
// prime-power discrete log digit solver.
// ----------------------------------------------------------------------------
package phds_pkg;

    localparam int WORD_W    = 64;
    localparam int TBL_DEPTH = 1024;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int JCNT_W    = TBL_AW + 1;
    localparam int Q_W       = 11;
    localparam int E_W       = 6;
    localparam int CFG_IDX_W = 2;
    localparam int BIT_W     = $clog2(WORD_W);

    localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_ORDER = 2'd2;

    typedef enum logic {
        ME_OP_MUL,
        ME_OP_POW
    } me_op_t;

    typedef struct packed {
        logic   start;
        me_op_t op;
    } me_req_t;

    typedef enum logic [1:0] {
        ME_IDLE,
        ME_DBL,
        ME_ADD
    } me_state_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV_ORD,
        S_RED_GEN,
        S_POW_BASE,
        S_TBL,
        S_RED_BETA,
        S_EUC_DIV,
        S_EUC_MUL,
        S_DIG_SETUP,
        S_DIG_DIV,
        S_DIG_MUL,
        S_DIG_POW,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DIG_ACC,
        S_GAM_POW,
        S_GAM_MUL,
        S_OUT
    } main_state_t;

endpackage

// File: hdl/phds_modexp.sv
// ----------------------------------------------------------------------------
// phds_modexp: shared modular multiply / exponentiate unit
// Multiplies a (reduced) by b modulo m with a bit-serial double-and-add;
// raises a to b by left-to-right square-multiply.
// ----------------------------------------------------------------------------
module phds_modexp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  phds_pkg::me_req_t             req,
    input  logic [phds_pkg::WORD_W-1:0]   a,
    input  logic [phds_pkg::WORD_W-1:0]   b,
    input  logic [phds_pkg::WORD_W-1:0]   m,
    output logic                          done,
    output logic [phds_pkg::WORD_W-1:0]   result
);
    import phds_pkg::*;

    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(WORD_W - 1);

    me_state_t         st_reg, st_next;
    logic              pow_reg, pow_next;
    logic              sq_reg, sq_next;
    logic [WORD_W-1:0] mx_reg, mx_next;
    logic [WORD_W-1:0] my_reg, my_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [WORD_W-1:0] base_reg, base_next;
    logic [WORD_W-1:0] exp_reg, exp_next;
    logic [BIT_W-1:0]  ebit_reg, ebit_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] res_reg, res_next;

    logic [WORD_W:0]   dbl_full, dbl_sub, sum_full, sum_sub;
    logic [WORD_W-1:0] dbl_red, sum_red, add_val;

    // double and add, each reduced by one compare-subtract
    always_comb
    begin
        dbl_full = {acc_reg, 1'b0};
        dbl_sub  = dbl_full - {1'b0, m};
        dbl_red  = (dbl_full >= {1'b0, m}) ? dbl_sub[WORD_W-1:0] : dbl_full[WORD_W-1:0];
        sum_full = {1'b0, acc_reg} + {1'b0, mx_reg};
        sum_sub  = sum_full - {1'b0, m};
        sum_red  = (sum_full >= {1'b0, m}) ? sum_sub[WORD_W-1:0] : sum_full[WORD_W-1:0];
        add_val  = my_reg[WORD_W-1] ? sum_red : acc_reg;
    end

    // sequence multiplier bits and exponent bits
    always_comb
    begin
        st_next   = st_reg;
        pow_next  = pow_reg;
        sq_next   = sq_reg;
        mx_next   = mx_reg;
        my_next   = my_reg;
        acc_next  = acc_reg;
        bit_next  = bit_reg;
        base_next = base_reg;
        exp_next  = exp_reg;
        ebit_next = ebit_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        unique case (st_reg)
            ME_IDLE:
            begin
                if (req.start)
                begin
                    acc_next = '0;
                    bit_next = '0;
                    st_next  = ME_DBL;
                    if (req.op == ME_OP_MUL)
                    begin
                        mx_next  = a;
                        my_next  = b;
                        pow_next = 1'b0;
                    end
                    else
                    begin
                        base_next = a;
                        exp_next  = b;
                        ebit_next = '0;
                        pow_next  = 1'b1;
                        sq_next   = 1'b1;
                        mx_next   = WORD_W'(1);
                        my_next   = WORD_W'(1);
                    end
                end
            end
            ME_DBL:
            begin
                acc_next = dbl_red;
                st_next  = ME_ADD;
            end
            ME_ADD:
            begin
                acc_next = add_val;
                my_next  = {my_reg[WORD_W-2:0], 1'b0};
                bit_next = bit_reg + 1'b1;
                st_next  = ME_DBL;
                if (bit_reg == BIT_LAST)
                begin
                    acc_next = '0;
                    bit_next = '0;
                    if (!pow_reg)
                    begin
                        res_next  = add_val;
                        done_next = 1'b1;
                        st_next   = ME_IDLE;
                    end
                    else if (sq_reg && exp_reg[WORD_W-1])
                    begin
                        sq_next = 1'b0;
                        mx_next = add_val;
                        my_next = base_reg;
                    end
                    else
                    begin
                        exp_next  = {exp_reg[WORD_W-2:0], 1'b0};
                        ebit_next = ebit_reg + 1'b1;
                        sq_next   = 1'b1;
                        mx_next   = add_val;
                        my_next   = add_val;
                        if (ebit_reg == BIT_LAST)
                        begin
                            res_next  = add_val;
                            done_next = 1'b1;
                            st_next   = ME_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                st_next = ME_IDLE;
            end
        endcase
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ME_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    // hold datapath
    always_ff @(posedge clk)
    begin
        pow_reg  <= pow_next;
        sq_reg   <= sq_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        acc_reg  <= acc_next;
        bit_reg  <= bit_next;
        base_reg <= base_next;
        exp_reg  <= exp_next;
        ebit_reg <= ebit_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

`ifndef SYNTHESIS
    a_done_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (res_reg < m))
        else $error("modexp result not reduced");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.start && st_reg == ME_IDLE) |=> (st_reg == ME_DBL))
        else $error("modexp failed to start");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (st_reg == ME_IDLE))
        else $error("modexp done while busy");
`endif

endmodule

// File: hdl/pohlig_hellman_prime_digit_solver_unit.sv
// ----------------------------------------------------------------------------
// pohlig_hellman_prime_digit_solver_unit: discrete log modulo a prime power
// Per item: builds the root power table, inverts the generator, then solves
// one base-q digit at a time and returns the log modulo q^e.
// ----------------------------------------------------------------------------
// Usage:
//   Write generator, modulus and group_order through cfg_we/cfg_index/cfg_data
//   while the block is idle. Present target, prime_factor and exponent with
//   in_valid; a transfer happens when in_valid is high and in_stall is low.
//   in_stall stays high from that transfer until the result has been taken.
//   The result appears on residue with out_valid and holds until a cycle with
//   out_stall low completes the transfer.
//   An item fills a table of min(q,1024) entries, runs the Euclid
//   inversion, and per digit computes two powers and searches up to
//   min(q,1024) table entries. Multiplies and powers share one modular
//   unit and divisions one divider. One item at a time.
//   Degenerate items (modulus below 2, prime_factor below 2, exponent 0) go
//   straight to the output with residue 0.
//   Reset returns the registers to generator 2, modulus 2, group order 1 and
//   idles the sequencer; the table needs no clearing.
// ----------------------------------------------------------------------------
module pohlig_hellman_prime_digit_solver_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [phds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [phds_pkg::WORD_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [phds_pkg::WORD_W-1:0]     target,
    input  logic [phds_pkg::Q_W-1:0]        prime_factor,
    input  logic [phds_pkg::E_W-1:0]        exponent,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [phds_pkg::WORD_W-1:0]     residue
);
    import phds_pkg::*;

    localparam logic [BIT_W-1:0]  BIT_LAST  = BIT_W'(WORD_W - 1);
    localparam logic [JCNT_W-1:0] TBL_LIMIT = JCNT_W'(TBL_DEPTH);

    // configuration
    logic [WORD_W-1:0] gen_reg, mod_reg, ord_reg;

    // sequencer and item state
    main_state_t       state_reg, state_next;
    logic              launched_reg, launched_next;
    logic [WORD_W-1:0] beta_reg, beta_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic [E_W-1:0]    e_reg, e_next;
    logic [E_W-1:0]    k_reg, k_next;
    logic [JCNT_W-1:0] tlen_reg, tlen_next;
    logic [JCNT_W-1:0] j_reg, j_next;
    logic [TBL_AW-1:0] digit_reg, digit_next;
    logic [WORD_W-1:0] tmp_reg, tmp_next;
    logic [WORD_W-1:0] gred_reg, gred_next;
    logic [WORD_W-1:0] bred_reg, bred_next;
    logic [WORD_W-1:0] base_reg, base_next;
    logic [WORD_W-1:0] tprev_reg, tprev_next;
    logic [WORD_W-1:0] r0_reg, r0_next, r1_reg, r1_next;
    logic [WORD_W-1:0] t0_reg, t0_next, t1_reg, t1_next;
    logic [WORD_W-1:0] eq_reg, eq_next;
    logic [WORD_W-1:0] ainv_reg, ainv_next;
    logic [WORD_W-1:0] gamma_reg, gamma_next;
    logic [WORD_W-1:0] pk_reg, pk_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] expo_reg, expo_next;
    logic [WORD_W-1:0] lhs_reg, lhs_next;

    // divider
    logic              dv_start;
    logic [WORD_W-1:0] dv_n, dv_d;
    logic              dv_busy_reg, dv_done_reg;
    logic [BIT_W-1:0]  dv_cnt_reg;
    logic [WORD_W-1:0] dv_rem_reg, dv_quo_reg, dv_d_reg;
    logic [WORD_W:0]   dv_trial, dv_diff;
    logic              dv_ge;

    // shared modular unit
    me_req_t           me_req;
    logic [WORD_W-1:0] me_a, me_b, me_res;
    logic              me_done;

    // table memory
    logic [WORD_W-1:0] tbl_mem [TBL_DEPTH];
    logic              mem_we;
    logic [TBL_AW-1:0] mem_wa;
    logic [WORD_W-1:0] mem_wd;
    logic [WORD_W-1:0] rd_reg;

    // small products and helpers
    logic [WORD_W+Q_W-1:0]    pkq_full;
    logic [WORD_W+TBL_AW-1:0] pkd_full;
    logic [WORD_W-1:0]        quo_red;
    logic                     in_xfer;

    assign pkq_full = pk_reg * q_reg;
    assign pkd_full = pk_reg * digit_reg;
    assign quo_red  = (dv_quo_reg >= mod_reg) ? (dv_quo_reg - mod_reg) : dv_quo_reg;
    assign in_xfer  = in_valid && !in_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg <= WORD_W'(2);
            mod_reg <= WORD_W'(2);
            ord_reg <= WORD_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GENERATOR:   gen_reg <= cfg_data;
                CFG_MODULUS:     mod_reg <= cfg_data;
                CFG_GROUP_ORDER: ord_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // restoring divider step
    always_comb
    begin
        dv_trial = {dv_rem_reg, dv_quo_reg[WORD_W-1]};
        dv_ge    = (dv_trial >= {1'b0, dv_d_reg});
        dv_diff  = dv_trial - {1'b0, dv_d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_busy_reg <= 1'b0;
            dv_done_reg <= 1'b0;
        end
        else
        begin
            dv_done_reg <= 1'b0;
            if (dv_start)
                dv_busy_reg <= 1'b1;
            else if (dv_busy_reg && dv_cnt_reg == BIT_LAST)
            begin
                dv_busy_reg <= 1'b0;
                dv_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_start)
        begin
            dv_rem_reg <= '0;
            dv_quo_reg <= dv_n;
            dv_d_reg   <= dv_d;
            dv_cnt_reg <= '0;
        end
        else if (dv_busy_reg)
        begin
            dv_rem_reg <= dv_ge ? dv_diff[WORD_W-1:0] : dv_trial[WORD_W-1:0];
            dv_quo_reg <= {dv_quo_reg[WORD_W-2:0], dv_ge};
            dv_cnt_reg <= dv_cnt_reg + 1'b1;
        end
    end

    phds_modexp u_modexp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (me_req),
        .a      (me_a),
        .b      (me_b),
        .m      (mod_reg),
        .done   (me_done),
        .result (me_res)
    );

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            tbl_mem[mem_wa] <= mem_wd;
        rd_reg <= tbl_mem[j_reg[TBL_AW-1:0]];
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        launched_next = launched_reg;
        beta_next     = beta_reg;
        q_next        = q_reg;
        e_next        = e_reg;
        k_next        = k_reg;
        tlen_next     = tlen_reg;
        j_next        = j_reg;
        digit_next    = digit_reg;
        tmp_next      = tmp_reg;
        gred_next     = gred_reg;
        bred_next     = bred_reg;
        base_next     = base_reg;
        tprev_next    = tprev_reg;
        r0_next       = r0_reg;
        r1_next       = r1_reg;
        t0_next       = t0_reg;
        t1_next       = t1_reg;
        eq_next       = eq_reg;
        ainv_next     = ainv_reg;
        gamma_next    = gamma_reg;
        pk_next       = pk_reg;
        acc_next      = acc_reg;
        expo_next     = expo_reg;
        lhs_next      = lhs_reg;
        dv_start      = 1'b0;
        dv_n          = ord_reg;
        dv_d          = {{(WORD_W-Q_W){1'b0}}, q_reg};
        me_req.start  = 1'b0;
        me_req.op     = ME_OP_MUL;
        me_a          = tprev_reg;
        me_b          = base_reg;
        mem_we        = 1'b0;
        mem_wa        = j_reg[TBL_AW-1:0];
        mem_wd        = me_res;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    beta_next = target;
                    q_next    = prime_factor;
                    e_next    = exponent;
                    tlen_next = (prime_factor < TBL_LIMIT) ? prime_factor : TBL_LIMIT;
                    acc_next  = '0;
                    if (mod_reg < WORD_W'(2) || prime_factor < Q_W'(2) || exponent == '0)
                        state_next = S_OUT;
                    else
                        state_next = S_DIV_ORD;
                end
            end
            S_DIV_ORD:
            begin
                if (!launched_reg)
                begin
                    dv_start      = 1'b1;
                    launched_next = 1'b1;
                end
                else if (dv_done_reg)
                begin
                    tmp_next      = dv_quo_reg;
                    launched_next = 1'b0;
                    state_next    = S_RED_GEN;
                end
            end
            S_RED_GEN:
            begin
                dv_n = gen_reg;
                dv_d = mod_reg;
                if (!launched_reg)
                begin
                    dv_start      = 1'b1;
                    launched_next = 1'b1;
                end
                else if (dv_done_reg)
                begin
                    gred_next     = dv_rem_reg;
                    launched_next = 1'b0;
                    state_next    = S_POW_BASE;
                end
            end
            S_POW_BASE:
            begin
                me_req.op = ME_OP_POW;
                me_a      = gred_reg;
                me_b      = tmp_reg;
                if (!launched_reg)
                begin
                    me_req.start  = 1'b1;
                    launched_next = 1'b1;
                end
                else if (me_done)
                begin
                    // first entry is the identity
                    base_next     = me_res;
                    mem_we        = 1'b1;
                    mem_wa        = '0;
                    mem_wd        = WORD_W'(1);
                    tprev_next    = WORD_W'(1);
                    j_next        = JCNT_W'(1);
                    launched_next = 1'b0;
                    state_next    = S_TBL;
                end
            end
            S_TBL:
            begin
                if (!launched_reg)
                begin
                    if (j_reg >= tlen_reg)
                        state_next = S_RED_BETA;
                    else
                    begin
                        me_req.start  = 1'b1;
                        launched_next = 1'b1;
                    end
                end
                else if (me_done)
                begin
                    mem_we        = 1'b1;
                    tprev_next    = me_res;
                    j_next        = j_reg + 1'b1;
                    launched_next = 1'b0;
                end
            end
            S_RED_BETA:
            begin
                dv_n = beta_reg;
                dv_d = mod_reg;
                if (!launched_reg)
                begin
                    dv_start      = 1'b1;
                    launched_next = 1'b1;
                end
                else if (dv_done_reg)
                begin
                    bred_next     = dv_rem_reg;
                    r0_next       = mod_reg;
                    r1_next       = gred_reg;
                    t0_next       = '0;
                    t1_next       = WORD_W'(1);
                    launched_next = 1'b0;
                    state_next    = S_EUC_DIV;
                end
            end
            S_EUC_DIV:
            begin
                dv_n = r0_reg;
                dv_d = r1_reg;
                if (!launched_reg)
                begin
                    if (r1_reg == '0)
                    begin
                        // no inverse unless the gcd is one
                        ainv_next  = (r0_reg == WORD_W'(1)) ? t0_reg : '0;
                        k_next     = '0;
                        pk_next    = WORD_W'(1);
                        gamma_next = WORD_W'(1);
                        state_next = S_DIG_SETUP;
                    end
                    else
                    begin
                        dv_start      = 1'b1;
                        launched_next = 1'b1;
                    end
                end
                else if (dv_done_reg)
                begin
                    eq_next       = quo_red;
                    r0_next       = r1_reg;
                    r1_next       = dv_rem_reg;
                    launched_next = 1'b0;
                    state_next    = S_EUC_MUL;
                end
            end
            S_EUC_MUL:
            begin
                me_a = eq_reg;
                me_b = t1_reg;
                if (!launched_reg)
                begin
                    me_req.start  = 1'b1;
                    launched_next = 1'b1;
                end
                else if (me_done)
                begin
                    t0_next       = t1_reg;
                    t1_next       = (t0_reg >= me_res) ? (t0_reg - me_res)
                                                       : (mod_reg - (me_res - t0_reg));
                    launched_next = 1'b0;
                    state_next    = S_EUC_DIV;
                end
            end
            S_DIG_SETUP:
            begin
                if (k_reg != '0)
                    pk_next = pkq_full[WORD_W-1:0];
                state_next = S_DIG_DIV;
            end
            S_DIG_DIV:
            begin
                dv_d = pkq_full[WORD_W-1:0];
                if (!launched_reg)
                begin
                    if (pkq_full[WORD_W-1:0] == '0)
                    begin
                        expo_next  = '0;
                        state_next = S_DIG_MUL;
                    end
                    else
                    begin
                        dv_start      = 1'b1;
                        launched_next = 1'b1;
                    end
                end
                else if (dv_done_reg)
                begin
                    expo_next     = dv_quo_reg;
                    launched_next = 1'b0;
                    state_next    = S_DIG_MUL;
                end
            end
            S_DIG_MUL:
            begin
                me_a = bred_reg;
                me_b = gamma_reg;
                if (!launched_reg)
                begin
                    me_req.start  = 1'b1;
                    launched_next = 1'b1;
                end
                else if (me_done)
                begin
                    tmp_next      = me_res;
                    launched_next = 1'b0;
                    state_next    = S_DIG_POW;
                end
            end
            S_DIG_POW:
            begin
                me_req.op = ME_OP_POW;
                me_a      = tmp_reg;
                me_b      = expo_reg;
                if (!launched_reg)
                begin
                    me_req.start  = 1'b1;
                    launched_next = 1'b1;
                end
                else if (me_done)
                begin
                    lhs_next      = me_res;
                    j_next        = '0;
                    digit_next    = '0;
                    launched_next = 1'b0;
                    state_next    = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                // first match wins; running off the end leaves digit zero
                if (rd_reg == lhs_reg)
                begin
                    digit_next = j_reg[TBL_AW-1:0];
                    state_next = S_DIG_ACC;
                end
                else if ((j_reg + 1'b1) >= tlen_reg)
                    state_next = S_DIG_ACC;
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_SRCH_RD;
                end
            end
            S_DIG_ACC:
            begin
                acc_next   = acc_reg + pkd_full[WORD_W-1:0];
                tmp_next   = pkd_full[WORD_W-1:0];
                state_next = S_GAM_POW;
            end
            S_GAM_POW:
            begin
                me_req.op = ME_OP_POW;
                me_a      = ainv_reg;
                me_b      = tmp_reg;
                if (!launched_reg)
                begin
                    me_req.start  = 1'b1;
                    launched_next = 1'b1;
                end
                else if (me_done)
                begin
                    tmp_next      = me_res;
                    launched_next = 1'b0;
                    state_next    = S_GAM_MUL;
                end
            end
            S_GAM_MUL:
            begin
                me_a = gamma_reg;
                me_b = tmp_reg;
                if (!launched_reg)
                begin
                    me_req.start  = 1'b1;
                    launched_next = 1'b1;
                end
                else if (me_done)
                begin
                    gamma_next    = me_res;
                    k_next        = k_reg + 1'b1;
                    launched_next = 1'b0;
                    if ((k_reg + 1'b1) == e_reg)
                        state_next = S_OUT;
                    else
                        state_next = S_DIG_SETUP;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            launched_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
        end
    end

    // hold datapath
    always_ff @(posedge clk)
    begin
        beta_reg  <= beta_next;
        q_reg     <= q_next;
        e_reg     <= e_next;
        k_reg     <= k_next;
        tlen_reg  <= tlen_next;
        j_reg     <= j_next;
        digit_reg <= digit_next;
        tmp_reg   <= tmp_next;
        gred_reg  <= gred_next;
        bred_reg  <= bred_next;
        base_reg  <= base_next;
        tprev_reg <= tprev_next;
        r0_reg    <= r0_next;
        r1_reg    <= r1_next;
        t0_reg    <= t0_next;
        t1_reg    <= t1_next;
        eq_reg    <= eq_next;
        ainv_reg  <= ainv_next;
        gamma_reg <= gamma_next;
        pk_reg    <= pk_next;
        acc_reg   <= acc_next;
        expo_reg  <= expo_next;
        lhs_reg   <= lhs_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign residue   = acc_reg;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != S_IDLE))
        else $error("transfer accepted but sequencer idle");
    a_div_launched: assert property (@(posedge clk) disable iff (!rst_n)
        dv_done_reg |-> launched_reg)
        else $error("divider finished without a request");
    a_me_launched: assert property (@(posedge clk) disable iff (!rst_n)
        me_done |-> launched_reg)
        else $error("modular unit finished without a request");
    a_single_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(dv_start && me_req.start))
        else $error("both shared units started together");
`endif

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: prime-power discrete log digit solver
// Drives target/prime_factor/exponent items under several register settings
// and idle patterns, predicts each residue in the bench, and checks results
// in order through a small scoreboard.
// ----------------------------------------------------------------------------
module testbench;

    import phds_pkg::*;

    localparam int TBL_MAX   = 1024;
    localparam int WDOG_MAX  = 9000000;
    localparam bit [63:0] WORD_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // Queue of predicted residues, oldest first
    class residue_board;
        bit [63:0] pending[$];

        function void note_item(bit [63:0] want);
            pending.push_back(want);
        endfunction

        // 0: match, 1: nothing pending, 2: wrong value
        function int check_result(bit [63:0] got, output bit [63:0] want);
            want = '0;
            if (pending.size() == 0)
                return 1;
            want = pending.pop_front();
            return (got == want) ? 0 : 2;
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [WORD_W-1:0]    target;
    logic [Q_W-1:0]       prime_factor;
    logic [E_W-1:0]       exponent;
    logic                 out_valid;
    logic                 out_stall;
    logic [WORD_W-1:0]    residue;

    residue_board board;
    int           err_count;
    int           send_idle_pct;
    int           stall_pct;
    int           quiet_cycles;
    bit [63:0]    gen_reg;
    bit [63:0]    mod_reg;
    bit [63:0]    ord_reg;

    pohlig_hellman_prime_digit_solver_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .target       (target),
        .prime_factor (prime_factor),
        .exponent     (exponent),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .residue      (residue)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Exact modular product through a double-width intermediate
    function automatic bit [63:0] mul_mod(bit [63:0] a, bit [63:0] b, bit [63:0] m);
        bit [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return 64'(prod % {64'd0, m});
    endfunction

    function automatic bit [63:0] pow_mod(bit [63:0] b, bit [63:0] e, bit [63:0] m);
        bit [63:0] acc;
        bit [63:0] sq;
        acc = 64'd1 % m;
        sq  = b % m;
        while (e != 0)
        begin
            if (e[0])
                acc = mul_mod(acc, sq, m);
            sq = mul_mod(sq, sq, m);
            e  = e >> 1;
        end
        return acc;
    endfunction

    // Extended Euclid; zero when no inverse exists
    function automatic bit [63:0] inv_mod(bit [63:0] a, bit [63:0] m);
        bit [63:0]  r0, r1, r2, t0, t1, t2, quo;
        bit [127:0] sum;
        r0 = m;
        r1 = a % m;
        t0 = 0;
        t1 = 64'd1 % m;
        while (r1 != 0)
        begin
            quo = r0 / r1;
            r2  = r0 - quo * r1;
            sum = {64'd0, t0} + {64'd0, (m - mul_mod(quo, t1, m)) % m};
            t2  = 64'(sum % {64'd0, m});
            r0 = r1;
            r1 = r2;
            t0 = t1;
            t1 = t2;
        end
        return (r0 == 1) ? t0 : 64'd0;
    endfunction

    // Log of beta modulo q^e, digit by digit
    function automatic bit [63:0] solve_residue(bit [63:0] beta, bit [63:0] q, bit [63:0] e);
        bit [63:0] pow_tbl[TBL_MAX];
        bit [63:0] tlen, base, ainv, gamma, pk, acc, dvsr, lhs, digit;
        if (mod_reg < 2 || q < 2)
            return 64'd0;
        tlen = (q < TBL_MAX) ? q : TBL_MAX;
        base = pow_mod(gen_reg, ord_reg / q, mod_reg);
        pow_tbl[0] = 1;
        for (int j = 1; j < tlen; j++)
            pow_tbl[j] = mul_mod(pow_tbl[j-1], base, mod_reg);
        ainv  = inv_mod(gen_reg, mod_reg);
        gamma = 1;
        pk    = 1;
        acc   = 0;
        for (int k = 0; k < e; k++)
        begin
            if (k != 0)
                pk = pk * q;
            dvsr  = pk * q;
            lhs   = pow_mod(mul_mod(beta, gamma, mod_reg),
                            (dvsr != 0) ? ord_reg / dvsr : 64'd0, mod_reg);
            digit = 0;
            for (int j = 0; j < tlen; j++)
            begin
                if (pow_tbl[j] == lhs)
                begin
                    digit = j;
                    break;
                end
            end
            acc   = acc + digit * pk;
            gamma = mul_mod(gamma, pow_mod(ainv, pk * digit, mod_reg), mod_reg);
        end
        return acc;
    endfunction

    task automatic report_mismatch(string what, bit [63:0] got, bit [63:0] want);
        err_count++;
        $display("MISMATCH %s: residue got %h want %h at %0t", what, got, want, $time);
    endtask

    // Write one register; the block must be idle and the caller drops the enable
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_GENERATOR:   gen_reg = val;
            CFG_MODULUS:     mod_reg = val;
            CFG_GROUP_ORDER: ord_reg = val;
            default: ;
        endcase
    endtask

    // Drop valid and wait until every expected result has come
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(bit [63:0] g, bit [63:0] p, bit [63:0] n);
        drain();
        write_reg(CFG_GENERATOR, g);
        write_reg(CFG_MODULUS, p);
        write_reg(CFG_GROUP_ORDER, n);
        cfg_we <= 1'b0;
    endtask

    // Offer one item and hold it until the transfer; valid stays up until
    // the next item, an idle cycle or a drain
    task automatic send_item(bit [63:0] beta, bit [10:0] q, bit [5:0] e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        target       <= beta;
        prime_factor <= q;
        exponent     <= e;
        do
            @(posedge clk);
        while (in_stall);
        board.note_item(solve_residue(beta, {53'd0, q}, {58'd0, e}));
    endtask

    // Mostly well-formed: target is a power of the generator, small prime
    task automatic send_random_item();
        int        pick;
        bit [10:0] q;
        bit [63:0] beta;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            // degenerate: prime factor below two or zero exponent
            if ($urandom_range(1))
                send_item({$urandom, $urandom}, 11'($urandom_range(1)), 6'($urandom_range(1, 63)));
            else
                send_item({$urandom, $urandom}, 11'($urandom_range(2, 7)), 6'd0);
        end
        else if (pick < 75)
        begin
            case ($urandom_range(3))
                0: q = 2;
                1: q = 3;
                2: q = 5;
                default: q = 7;
            endcase
            beta = pow_mod(gen_reg, {$urandom, $urandom}, mod_reg);
            send_item(beta, q, 6'($urandom_range(1, 3)));
        end
        else if (pick < 95)
            send_item({$urandom, $urandom}, 11'($urandom_range(2, 16)), 6'($urandom_range(1, 4)));
        else
            send_item({$urandom, $urandom}, 11'($urandom_range(17, 2047)), 6'd1);
    endtask

    // Receive side: random stall, check every transfer
    always @(posedge clk)
    begin
        bit [63:0] want;
        int        status;
        if (rst_n && out_valid && !out_stall)
        begin
            status = board.check_result(residue, want);
            if (status == 1)
                report_mismatch("unexpected result", residue, want);
            else if (status == 2)
                report_mismatch("wrong value", residue, want);
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: count cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        board         = new();
        err_count     = 0;
        quiet_cycles  = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        gen_reg       = 64'd2;
        mod_reg       = 64'd2;
        ord_reg       = 64'd1;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        target        = '0;
        prime_factor  = '0;
        exponent      = '0;
        out_stall     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings first
        send_item(64'd1, 11'd2, 6'd1);
        set_config(64'd3, 64'd65537, 64'd65536);
        send_item(64'd0, 11'd2, 6'd1);
        send_item(WORD_ONES, 11'd2, 6'd4);
        send_item(pow_mod(3, 12345, 65537), 11'd2, 6'd16);
        send_item(pow_mod(3, 777, 65537), 11'd2, 6'd63);
        send_item(64'd5, 11'd3, 6'd2);
        send_item(64'd9, 11'd0, 6'd5);
        send_item(64'd9, 11'd1, 6'd5);
        send_item(64'd9, 11'd2, 6'd0);
        send_item(64'd81, 11'd1024, 6'd7);
        send_item(64'd81, 11'd2047, 6'd1);
        send_item(64'h5555_AAAA_5555_AAAA, 11'd1365, 6'd1);
        send_item(64'd2, 11'd682, 6'd42);
        // generator without an inverse
        set_config(64'd0, 64'd65537, 64'd65536);
        send_item(64'd1, 11'd2, 6'd2);
        // modulus below two
        set_config(64'd3, 64'd1, 64'd65536);
        send_item(64'd7, 11'd2, 6'd3);
        // largest values
        set_config(WORD_ONES, 64'hFFFF_FFFF_FFFF_FFC5, WORD_ONES);
        send_item(WORD_ONES, 11'd3, 6'd2);

        // Random phases under different idle patterns
        set_config(64'd17, 64'd7681, 64'd7680);
        for (int i = 0; i < 22; i++)
        begin
            send_random_item();
            if (i == 10)
                drain();
        end

        set_config(64'd3, 64'd65537, 64'd65536);
        send_idle_pct = 47;
        for (int i = 0; i < 22; i++)
            send_random_item();

        set_config(64'd5, 64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFC4);
        send_idle_pct = 0;
        stall_pct     = 47;
        for (int i = 0; i < 22; i++)
            send_random_item();

        set_config({$urandom, $urandom}, {$urandom, $urandom} | 64'd2, {$urandom, $urandom});
        send_idle_pct = 24;
        stall_pct     = 24;
        for (int i = 0; i < 22; i++)
            send_random_item();

        drain();
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
